### sv/utg_pkg.sv
// ============================================================================
// UTF-8 to GB2312 converter package
// Table sizing, queue sizing, codes and the front-to-back queue entry type.
// ============================================================================
package utg_pkg;

    localparam int TABLE_DEPTH = 8192;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_OUTPUT_LIMIT = 1'b0;
    localparam logic CFG_ENTRIES_USED = 1'b1;

    localparam logic [7:0] UNKNOWN_CHAR = 8'h3F;

    // One queue entry. For a text entry the key holds the decoded code point
    // cut to 16 bits.
    typedef struct packed {
        logic        is_load;
        logic        has_char;
        logic        is_ascii;
        logic        is_end;
        logic [15:0] key;
        logic [15:0] code;
        logic [12:0] index;
    } q_entry_t;

    typedef struct packed {
        logic [15:0] limit;
        logic [13:0] entries;
    } cfg_t;

endpackage

### sv/utf8_to_gb2312_converter.sv
// ============================================================================
// UTF-8 to GB2312 converter
// Streams UTF-8 text in and GB2312 bytes out through an 8192-entry sorted
// lookup table that is loaded over the same input stream.
// ============================================================================
// The front end takes one input transfer per cycle while its four-entry
// command queue has room; the back end works through the queue one command at
// a time. A table load is written from the idle state. A character below 0x80
// passes through the first emit state to the output register. A table lookup
// is a binary search over the single-port table memory, each probe a read
// state (address) and then a compare state. A miss ends with one more check of
// the empty window and then emits the unknown character, while a hit emits its
// second GB2312 byte from a second emit state. The end-of-string transfer is
// sent from its own end state. The output register lets the front end keep
// accepting while a result waits on m_tready. The table has no reset and need
// not be cleared.
module utf8_to_gb2312_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: entry_index[12:0], entry_code_point[28:13], entry_gb_code[44:29],
    //          text_byte[52:45], zero fill[55:53]
    input  logic [55:0] s_tdata,
    // s_tuser: operation[0]
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: out_byte[7:0], out_count[23:8]
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]       limit_reg;
    logic [13:0]       entries_reg;
    utg_pkg::cfg_t     cfg;
    utg_pkg::q_entry_t push_entry;
    utg_pkg::q_entry_t head;
    logic              q_push, q_pop, q_empty, q_full;
    logic [7:0]        out_byte;
    logic [15:0]       out_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= 16'hFFFF;
            entries_reg <= 14'd0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                utg_pkg::CFG_OUTPUT_LIMIT: limit_reg   <= cfg_wdata;
                utg_pkg::CFG_ENTRIES_USED: entries_reg <= cfg_wdata[13:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.limit   = limit_reg;
    assign cfg.entries = entries_reg;

    utg_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_tvalid),
        .op               (s_tuser),
        .entry_index      (s_tdata[12:0]),
        .entry_code_point (s_tdata[28:13]),
        .entry_gb_code    (s_tdata[44:29]),
        .text_byte        (s_tdata[52:45]),
        .text_last        (s_tlast),
        .q_full           (q_full),
        .s_ready          (s_tready),
        .q_push           (q_push),
        .q_entry          (push_entry)
    );

    utg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    utg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .q_empty (q_empty),
        .cfg     (cfg),
        .m_ready (m_tready),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_byte  (out_byte),
        .m_end   (m_tlast),
        .m_count (out_count)
    );

    assign m_tdata = {out_count, out_byte};

`ifndef ASSERT_OFF
    // The back end only takes a command that is really in the queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> !q_empty)
        else $error("command queue popped while empty");

    // Every byte transfer is counted, so its running count is never zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[23:8] != 16'h0000))
        else $error("byte result carries a zero count");

    // The end-of-string transfer carries a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[7:0] == 8'h00))
        else $error("end result carries a nonzero byte");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

### sv/utg_front.sv
// ============================================================================
// UTF-8 decode front end
// Accepts input items, tracks multi-byte sequences and pushes load, character
// and end-of-string commands into the queue.
// ============================================================================
module utg_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              op,
    input  logic [12:0]       entry_index,
    input  logic [15:0]       entry_code_point,
    input  logic [15:0]       entry_gb_code,
    input  logic [7:0]        text_byte,
    input  logic              text_last,
    input  logic              q_full,
    output logic              s_ready,
    output logic              q_push,
    output utg_pkg::q_entry_t q_entry
);

    logic [20:0] pcp_reg, pcp_next;
    logic [1:0]  rem_reg, rem_next;
    logic        halt_reg, halt_next;
    logic [20:0] cp_c;
    logic        char_v;
    logic        accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pcp_next  = pcp_reg;
        rem_next  = rem_reg;
        halt_next = halt_reg;
        cp_c      = 21'd0;
        char_v    = 1'b0;
        if (op == utg_pkg::OP_TEXT) begin
            if (!halt_reg) begin
                if (text_byte == 8'h00) begin
                    halt_next = 1'b1;
                end else if (rem_reg != 2'd0) begin
                    // Continuation bytes are taken as they come.
                    cp_c     = {pcp_reg[14:0], text_byte[5:0]};
                    pcp_next = cp_c;
                    rem_next = rem_reg - 2'd1;
                    if (rem_reg == 2'd1) begin
                        if (cp_c == 21'd0) begin
                            halt_next = 1'b1;
                        end else begin
                            char_v = 1'b1;
                        end
                    end
                end else if (!text_byte[7]) begin
                    cp_c   = {13'd0, text_byte};
                    char_v = 1'b1;
                end else if (text_byte[7:5] == 3'b110) begin
                    pcp_next = {16'd0, text_byte[4:0]};
                    rem_next = 2'd1;
                end else if (text_byte[7:4] == 4'b1110) begin
                    pcp_next = {17'd0, text_byte[3:0]};
                    rem_next = 2'd2;
                end else if (text_byte[7:3] == 5'b11110) begin
                    pcp_next = {18'd0, text_byte[2:0]};
                    rem_next = 2'd3;
                end else begin
                    halt_next = 1'b1;
                end
            end
            if (text_last) begin
                pcp_next  = 21'd0;
                rem_next  = 2'd0;
                halt_next = 1'b0;
            end
        end
    end

    always_comb begin
        q_entry.is_load  = (op == utg_pkg::OP_LOAD);
        q_entry.has_char = char_v;
        q_entry.is_ascii = (cp_c[20:7] == 14'd0);
        q_entry.is_end   = (op == utg_pkg::OP_TEXT) && text_last;
        q_entry.key      = (op == utg_pkg::OP_LOAD) ? entry_code_point : cp_c[15:0];
        q_entry.code     = entry_gb_code;
        q_entry.index    = entry_index;
    end

    // Items that change nothing downstream are accepted without a queue entry.
    assign q_push = accept && (q_entry.is_load || char_v || q_entry.is_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pcp_reg  <= 21'd0;
            rem_reg  <= 2'd0;
            halt_reg <= 1'b0;
        end else if (accept) begin
            pcp_reg  <= pcp_next;
            rem_reg  <= rem_next;
            halt_reg <= halt_next;
        end
    end

endmodule

### sv/utg_queue.sv
// ============================================================================
// Command queue
// Short first-in first-out buffer between the decode front end and the
// lookup back end.
// ============================================================================
module utg_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  utg_pkg::q_entry_t push_entry,
    input  logic              pop,
    output utg_pkg::q_entry_t head,
    output logic              empty,
    output logic              full
);

    utg_pkg::q_entry_t             entry_reg [utg_pkg::QUEUE_DEPTH];
    logic [utg_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [utg_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [utg_pkg::QPTR_W:0]      count_reg, count_next;
    logic                          do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (utg_pkg::QPTR_W + 1)'(utg_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + utg_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + utg_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (utg_pkg::QPTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (utg_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/utg_back.sv
// ============================================================================
// Lookup and output back end
// Holds the mapping table, runs the binary search, applies the output limit
// and drives the result register.
// ============================================================================
module utg_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  utg_pkg::q_entry_t head,
    input  logic              q_empty,
    input  utg_pkg::cfg_t     cfg,
    input  logic              m_ready,
    output logic              q_pop,
    output logic              m_valid,
    output logic [7:0]        m_byte,
    output logic              m_end,
    output logic [15:0]       m_count
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_EMIT1 = 3'd3;
    localparam logic [2:0] ST_EMIT2 = 3'd4;
    localparam logic [2:0] ST_END   = 3'd5;

    localparam int CNT_W  = utg_pkg::CNT_W;
    localparam int ADDR_W = utg_pkg::ADDR_W;

    logic [15:0] key_mem  [utg_pkg::TABLE_DEPTH];
    logic [15:0] code_mem [utg_pkg::TABLE_DEPTH];
    logic [15:0] rd_key_reg, rd_code_reg;

    logic [2:0]        state_reg, state_next;
    logic [15:0]       key_reg, key_next;
    logic              end_reg, end_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hx_reg, hx_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic [7:0]        byte1_reg, byte1_next;
    logic [7:0]        byte2_reg, byte2_next;
    logic              two_reg, two_next;
    logic [15:0]       count_reg, count_next;
    logic              halted_reg, halted_next;
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_byte_reg, m_byte_next;
    logic              m_end_reg, m_end_next;
    logic [15:0]       m_count_reg, m_count_next;

    logic [CNT_W-1:0]  n_used;
    logic [CNT_W:0]    mid_sum;
    logic [ADDR_W-1:0] mid_c;
    logic              fits1, fits2;
    logic              out_free;
    logic              mem_we, mem_re;
    logic [2:0]        after_char;

    assign n_used  = (cfg.entries > utg_pkg::TABLE_DEPTH) ? CNT_W'(utg_pkg::TABLE_DEPTH)
                                                          : CNT_W'(cfg.entries);
    // The search window is [lo, hx); its midpoint rounds down like (lo + hi) / 2.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hx_reg} - (CNT_W + 1)'(1);
    assign mid_c   = mid_sum[ADDR_W:1];

    assign fits1      = ({1'b0, count_reg} + 17'd1) <= {1'b0, cfg.limit};
    assign fits2      = ({1'b0, count_reg} + 17'd2) <= {1'b0, cfg.limit};
    assign out_free   = !m_valid_reg || m_ready;
    assign after_char = end_reg ? ST_END : ST_IDLE;

    assign mem_we = (state_reg == ST_IDLE) && !q_empty && head.is_load
                    && (head.index < utg_pkg::TABLE_DEPTH);
    assign mem_re = (state_reg == ST_READ) && (lo_reg < hx_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[ADDR_W'(head.index)]  <= head.key;
            code_mem[ADDR_W'(head.index)] <= head.code;
        end
        if (mem_re) begin
            rd_key_reg  <= key_mem[mid_c];
            rd_code_reg <= code_mem[mid_c];
        end
    end

    always_comb begin
        state_next   = state_reg;
        key_next     = key_reg;
        end_next     = end_reg;
        lo_next      = lo_reg;
        hx_next      = hx_reg;
        mid_next     = mid_reg;
        byte1_next   = byte1_reg;
        byte2_next   = byte2_reg;
        two_next     = two_reg;
        count_next   = count_reg;
        halted_next  = halted_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_byte_next  = m_byte_reg;
        m_end_next   = m_end_reg;
        m_count_next = m_count_reg;
        q_pop        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    key_next = head.key;
                    end_next = head.is_end;
                    if (head.is_load) begin
                        state_next = ST_IDLE;
                    end else if (head.has_char && !halted_reg) begin
                        if (head.is_ascii) begin
                            if (fits1) begin
                                byte1_next = head.key[7:0];
                                two_next   = 1'b0;
                                state_next = ST_EMIT1;
                            end else begin
                                halted_next = 1'b1;
                                state_next  = head.is_end ? ST_END : ST_IDLE;
                            end
                        end else begin
                            lo_next    = '0;
                            hx_next    = n_used;
                            state_next = ST_READ;
                        end
                    end else if (head.is_end) begin
                        state_next = ST_END;
                    end
                end
            end
            ST_READ: begin
                if (lo_reg < hx_reg) begin
                    mid_next   = mid_c;
                    state_next = ST_CMP;
                end else if (fits1) begin
                    byte1_next = utg_pkg::UNKNOWN_CHAR;
                    two_next   = 1'b0;
                    state_next = ST_EMIT1;
                end else begin
                    halted_next = 1'b1;
                    state_next  = after_char;
                end
            end
            ST_CMP: begin
                if (rd_key_reg == key_reg) begin
                    if (fits2) begin
                        byte1_next = rd_code_reg[15:8];
                        byte2_next = rd_code_reg[7:0];
                        two_next   = 1'b1;
                        state_next = ST_EMIT1;
                    end else begin
                        halted_next = 1'b1;
                        state_next  = after_char;
                    end
                end else begin
                    if (rd_key_reg < key_reg) begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end else begin
                        hx_next = CNT_W'(mid_reg);
                    end
                    state_next = ST_READ;
                end
            end
            ST_EMIT1: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = byte1_reg;
                    m_end_next   = 1'b0;
                    m_count_next = count_reg + 16'd1;
                    count_next   = count_reg + 16'd1;
                    state_next   = two_reg ? ST_EMIT2 : after_char;
                end
            end
            ST_EMIT2: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = byte2_reg;
                    m_end_next   = 1'b0;
                    m_count_next = count_reg + 16'd1;
                    count_next   = count_reg + 16'd1;
                    state_next   = after_char;
                end
            end
            ST_END: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = 8'h00;
                    m_end_next   = 1'b1;
                    m_count_next = count_reg;
                    count_next   = 16'd0;
                    halted_next  = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= 16'd0;
            halted_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            halted_reg  <= halted_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        end_reg     <= end_next;
        lo_reg      <= lo_next;
        hx_reg      <= hx_next;
        mid_reg     <= mid_next;
        byte1_reg   <= byte1_next;
        byte2_reg   <= byte2_next;
        two_reg     <= two_next;
        m_byte_reg  <= m_byte_next;
        m_end_reg   <= m_end_next;
        m_count_reg <= m_count_next;
    end

    assign m_valid = m_valid_reg;
    assign m_byte  = m_byte_reg;
    assign m_end   = m_end_reg;
    assign m_count = m_count_reg;

endmodule

### verif/utg_conversion_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 to GB2312 conversion checker
// Watches the input, result and register write ports of the converter, keeps
// its own copy of the lookup table and string state, predicts every result
// byte and end marker, and compares each result transfer in order.
// ============================================================================
module utg_conversion_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic [15:0] count;
    } gb_result_t;

    logic [15:0] key_mem [utg_pkg::TABLE_DEPTH];
    logic [15:0] gb_mem  [utg_pkg::TABLE_DEPTH];
    logic [15:0] limit_reg;
    logic [13:0] used_reg;
    logic [20:0] cp_acc;
    logic [1:0]  cont_left;
    logic        stopped;
    logic [15:0] byte_count;
    gb_result_t  expected_out_q[$];
    int          err_total = 0;

    task automatic push_byte(input logic [7:0] b);
        byte_count = byte_count + 16'd1;
        expected_out_q.push_back('{data: b, fin: 1'b0, count: byte_count});
    endtask

    task automatic clear_string();
        cp_acc     = '0;
        cont_left  = '0;
        stopped    = 1'b0;
        byte_count = '0;
    endtask

    // One finished character: pass-through, table hit, miss, or a halt.
    task automatic emit_char(input logic [20:0] cp);
        int          lo;
        int          hi;
        int          mid;
        logic        hit;
        logic [15:0] gb;
        hit = 1'b0;
        gb  = '0;
        if (cp == '0) begin
            stopped = 1'b1;
        end else if (cp < 21'h80) begin
            if (int'(byte_count) + 1 > int'(limit_reg)) stopped = 1'b1;
            else push_byte(cp[7:0]);
        end else begin
            lo = 0;
            hi = (int'(used_reg) > utg_pkg::TABLE_DEPTH ? utg_pkg::TABLE_DEPTH
                                                        : int'(used_reg)) - 1;
            while (!hit && lo <= hi) begin
                mid = (lo + hi) / 2;
                if (key_mem[mid] == cp[15:0]) begin
                    hit = 1'b1;
                    gb  = gb_mem[mid];
                end else if (key_mem[mid] < cp[15:0]) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
            if (hit) begin
                if (int'(byte_count) + 2 > int'(limit_reg)) begin
                    stopped = 1'b1;
                end else begin
                    push_byte(gb[15:8]);
                    push_byte(gb[7:0]);
                end
            end else if (int'(byte_count) + 1 > int'(limit_reg)) begin
                stopped = 1'b1;
            end else begin
                push_byte(utg_pkg::UNKNOWN_CHAR);
            end
        end
    endtask

    task automatic take_item(input logic op, input logic [55:0] d, input logic last);
        logic [7:0] b;
        b = d[52:45];
        if (op == utg_pkg::OP_LOAD) begin
            key_mem[d[12:0]] = d[28:13];
            gb_mem[d[12:0]]  = d[44:29];
        end else begin
            if (!stopped) begin
                if (b == 8'h00) begin
                    stopped = 1'b1;
                end else if (cont_left != 2'd0) begin
                    // Continuation bytes are taken as they come, top bits unchecked.
                    cp_acc    = {cp_acc[14:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) emit_char(cp_acc);
                end else if (!b[7]) begin
                    emit_char({13'd0, b});
                end else if (b[7:5] == 3'b110) begin
                    cp_acc    = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    cp_acc    = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    cp_acc    = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end else begin
                    stopped = 1'b1;
                end
            end
            if (last) begin
                expected_out_q.push_back('{data: 8'h00, fin: 1'b1, count: byte_count});
                clear_string();
            end
        end
    endtask

    always @(posedge aclk) begin
        gb_result_t exp_res;
        if (!aresetn) begin
            clear_string();
            limit_reg = 16'hFFFF;
            used_reg  = '0;
            expected_out_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == utg_pkg::CFG_OUTPUT_LIMIT) limit_reg = cfg_wdata;
                else used_reg = cfg_wdata[13:0];
            end
            if (m_tvalid && m_tready) begin
                if (expected_out_q.size() == 0) begin
                    err_total++;
                    $display("%0t: unexpected result byte %02h end %0b count %0d",
                             $time, m_tdata[7:0], m_tlast, m_tdata[23:8]);
                end else begin
                    exp_res = expected_out_q.pop_front();
                    if (m_tdata[7:0] !== exp_res.data || m_tlast !== exp_res.fin ||
                        m_tdata[23:8] !== exp_res.count) begin
                        err_total++;
                        $display({"%0t: result mismatch, expected byte %02h end %0b ",
                                  "count %0d, got byte %02h end %0b count %0d"},
                                 $time, exp_res.data, exp_res.fin, exp_res.count,
                                 m_tdata[7:0], m_tlast, m_tdata[23:8]);
                    end
                end
            end
            if (s_tvalid && s_tready) take_item(s_tuser, s_tdata, s_tlast);
        end
        pending    <= expected_out_q.size();
        fail_count <= err_total;
    end

endmodule

### verif/tb_utf8_to_gb2312_converter.sv
`timescale 1ns / 1ps
// ============================================================================
// UTF-8 to GB2312 converter testbench
// Loads sorted lookup tables, streams directed and random UTF-8 strings under
// several limit and table-size settings with random gaps on both channels,
// and reports the verdict from the conversion checker.
// ============================================================================
module tb_utf8_to_gb2312_converter;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles = 0;
    logic [15:0] tab_key [utg_pkg::TABLE_DEPTH];
    logic [7:0]  str_bytes[$];
    int          last_len;

    utf8_to_gb2312_converter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    utg_conversion_checker conv_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Ends the run when neither channel has moved a transfer for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("utf8_to_gb2312_converter verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [12:0] idx, input logic [15:0] key,
                             input logic [15:0] gb, input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99, 0) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {3'b000, b, gb, key, idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_load(input logic [12:0] idx, input logic [15:0] key,
                             input logic [15:0] gb);
        send_item(utg_pkg::OP_LOAD, idx, key, gb, 8'($urandom), $urandom_range(3, 0) == 0);
    endtask

    // Lowers valid and holds off until every predicted result has arrived.
    task automatic drain(input bit settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Strictly increasing keys, one per slice of the 16-bit key space.
    task automatic load_table(input int n);
        int span;
        span = (n > 0) ? 65536 / n : 1;
        for (int i = 0; i < n; i++) begin
            tab_key[i] = 16'(i * span + $urandom_range(span - 1, 0));
            send_load(13'(i), tab_key[i], 16'($urandom));
        end
    endtask

    // Either rewrites the code of a live entry or fills a slot past the table.
    task automatic random_load(input int n);
        int i;
        if (n < utg_pkg::TABLE_DEPTH && $urandom_range(1, 0) == 1) begin
            send_load(13'($urandom_range(utg_pkg::TABLE_DEPTH - 1, n)), 16'($urandom),
                      16'($urandom));
        end else if (n > 0) begin
            i = $urandom_range(n - 1, 0);
            send_load(13'(i), tab_key[i], 16'($urandom));
        end
    endtask

    function automatic logic [7:0] cont_byte(input logic [5:0] bits6);
        if ($urandom_range(9, 0) == 0) return {2'($urandom), bits6};
        return {2'b10, bits6};
    endfunction

    task automatic put_seq(input logic [20:0] cp, input int len);
        case (len)
            1: begin
                str_bytes.push_back(cp[7:0]);
            end
            2: begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back(cont_byte(cp[5:0]));
            end
            3: begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back(cont_byte(cp[11:6]));
                str_bytes.push_back(cont_byte(cp[5:0]));
            end
            default: begin
                str_bytes.push_back({5'b11110, cp[20:18]});
                str_bytes.push_back(cont_byte(cp[17:12]));
                str_bytes.push_back(cont_byte(cp[11:6]));
                str_bytes.push_back(cont_byte(cp[5:0]));
            end
        endcase
        last_len = len;
    endtask

    task automatic add_random_char(input int n);
        int          pick;
        logic [15:0] k;
        pick = $urandom_range(99, 0);
        if (pick < 25) begin
            put_seq(21'($urandom_range(127, 1)), 1);
        end else if (pick < 60 && n > 0) begin
            k = tab_key[$urandom_range(n - 1, 0)];
            // Keys below 0x80 can only be reached through a four-byte alias.
            if (k < 16'h80 || $urandom_range(4, 0) == 0) put_seq({5'($urandom_range(31, 1)), k}, 4);
            else if (k < 16'h800) put_seq({5'd0, k}, 2);
            else put_seq({5'd0, k}, 3);
        end else if (pick < 80) begin
            put_seq(21'($urandom), $urandom_range(4, 2));
        end else if (pick < 92) begin
            str_bytes.push_back(8'($urandom));
            last_len = 1;
        end else begin
            // Overlong forms, some of which decode to a zero code point.
            put_seq(21'($urandom_range(127, 0)), $urandom_range(3, 2));
        end
    endtask

    task automatic send_bytes(input int n);
        foreach (str_bytes[i]) begin
            if ($urandom_range(99, 0) < 8) random_load(n);
            send_item(utg_pkg::OP_TEXT, 13'($urandom), 16'($urandom), 16'($urandom),
                      str_bytes[i], i == str_bytes.size() - 1);
        end
        str_bytes.delete();
    endtask

    task automatic send_string(input int n);
        int chars;
        chars = $urandom_range(5, 1);
        repeat (chars) add_random_char(n);
        // Now and then the string ends inside its final character.
        if (last_len > 1 && $urandom_range(9, 0) == 0)
            repeat ($urandom_range(last_len - 1, 1)) void'(str_bytes.pop_back());
        send_bytes(n);
    endtask

    task automatic run_phase(input logic [15:0] limit, input int entries, input int strings,
                             input int send_pct, input int recv_pct);
        int n;
        n = (entries > utg_pkg::TABLE_DEPTH) ? utg_pkg::TABLE_DEPTH : entries;
        drain(1);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_reg(utg_pkg::CFG_OUTPUT_LIMIT, limit);
        write_reg(utg_pkg::CFG_ENTRIES_USED, 16'(entries));
        load_table(n);
        for (int s = 0; s < strings; s++) begin
            if (s == strings / 2) drain(0);
            send_string(n);
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= utg_pkg::OP_LOAD;
        s_tlast   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= utg_pkg::CFG_OUTPUT_LIMIT;
        cfg_wdata <= '0;
        send_idle_pct = 38;
        recv_idle_pct = 67;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(utg_pkg::CFG_OUTPUT_LIMIT, 16'hFFFF);
        write_reg(utg_pkg::CFG_ENTRIES_USED, 16'd16);
        load_table(16);
        // A load flagged as last must not close the string.
        send_item(utg_pkg::OP_LOAD, 13'd16, 16'hFFFF, 16'h1234, 8'h41, 1'b1);

        // ASCII, an overlong pass-through, hits and the largest code point.
        str_bytes = '{8'h41, 8'h7F, 8'hC1, 8'h81};
        put_seq({5'd1, tab_key[0]}, 4);
        put_seq({5'd0, tab_key[15]}, 3);
        put_seq(21'h1FFFFF, 4);
        send_bytes(16);
        // Zero code point halts; the rest of the string is ignored.
        str_bytes = '{8'hC0, 8'h80, 8'h41};
        send_bytes(16);
        // Continuation byte as lead.
        str_bytes = '{8'h80};
        send_bytes(16);
        // Lead byte at 0xF8 and above.
        str_bytes = '{8'hFF, 8'h41};
        send_bytes(16);
        // Zero byte.
        str_bytes = '{8'h00, 8'h42};
        send_bytes(16);
        // String ends inside a three-byte sequence.
        str_bytes = '{8'hE4, 8'hB8};
        send_bytes(16);

        run_phase(16'hFFFF, 1, 5, 38, 67);
        run_phase(16'd7, 24, 6, 38, 67);
        run_phase(16'd1, 11, 4, 67, 38);
        run_phase(16'd0, 0, 3, 67, 38);
        run_phase(16'($urandom_range(65535, 20)), 32, 7, 0, 0);
        run_phase(16'hFFFF, $urandom_range(20, 1), 5, 0, 0);

        drain(1);
        if (fail_count == 0) begin
            $display("utf8_to_gb2312_converter verification clean");
        end else begin
            $display("utf8_to_gb2312_converter verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/utg_pkg.sv
sv/utg_front.sv
sv/utg_queue.sv
sv/utg_back.sv
sv/utf8_to_gb2312_converter.sv
verif/utg_conversion_checker.sv
verif/tb_utf8_to_gb2312_converter.sv
